// ----- design/command_frame_encoder_crc16_assert.svh -----
// Assertion macros shared by the encoder modules.
`ifndef COMMAND_FRAME_ENCODER_CRC16_ASSERT_SVH
`define COMMAND_FRAME_ENCODER_CRC16_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cfe_pkg.sv -----
package cfe_pkg;

  localparam logic [7:0]  HDR0     = 8'hA5;
  localparam logic [7:0]  HDR1     = 8'h5A;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [3:0]  CRC_SPAN = 4'd10;
  localparam logic [3:0]  LAST_IDX = 4'd11;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [31:0] payload_value;
  } frame_req_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ----- design/cfe_front.sv -----
module cfe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_command,
  input  logic [7:0]          in_arg_a,
  input  logic [7:0]          in_arg_b,
  input  logic [7:0]          in_arg_c,
  input  logic [31:0]         in_payload_value,
  output logic                push_valid,
  input  logic                push_ready,
  output cfe_pkg::frame_req_t push_data
);

  logic                valid_r;
  cfe_pkg::frame_req_t req_r;
  logic                in_take;

  assign in_ready   = !valid_r || push_ready;
  assign in_take    = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_data  = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_take) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.command       <= in_command;
      req_r.arg_a         <= in_arg_a;
      req_r.arg_b         <= in_arg_b;
      req_r.arg_c         <= in_arg_c;
      req_r.payload_value <= in_payload_value;
    end
  end

endmodule

// ----- design/cfe_queue.sv -----
`include "command_frame_encoder_crc16_assert.svh"

module cfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cfe_pkg::frame_req_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cfe_pkg::frame_req_t pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cfe_pkg::frame_req_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CFE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "Queue count exceeds depth.")
  `CFE_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + CW'(1),
                  "Queue count did not grow on a lone push.")
  `CFE_ASSERT_NXT(a_count_down, pop && !push, count_r == $past(count_r) - CW'(1),
                  "Queue count did not shrink on a lone pop.")

endmodule

// ----- design/cfe_back.sv -----
`include "command_frame_encoder_crc16_assert.svh"

module cfe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  cfe_pkg::frame_req_t q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_frame_byte,
  output logic [3:0]          out_byte_index,
  output logic                out_last_byte
);

  cfe_pkg::frame_req_t req_r;
  logic        busy_r;
  logic [3:0]  idx_r;
  logic [15:0] crc_r;
  logic        out_valid_r;
  logic [7:0]  out_frame_byte_r;
  logic [3:0]  out_byte_index_r;
  logic        out_last_byte_r;
  logic        advance;
  logic        frame_done;
  logic        load;
  logic [7:0]  byte_sel;

  assign advance    = busy_r && (!out_valid_r || out_ready);
  assign frame_done = advance && (idx_r == cfe_pkg::LAST_IDX);
  assign load       = q_valid && (!busy_r || frame_done);
  assign q_ready    = !busy_r || frame_done;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_byte_index = out_byte_index_r;
  assign out_last_byte  = out_last_byte_r;

  always_comb begin
    case (idx_r)
      4'd0:    byte_sel = cfe_pkg::HDR0;
      4'd1:    byte_sel = cfe_pkg::HDR1;
      4'd2:    byte_sel = req_r.command;
      4'd3:    byte_sel = req_r.arg_a;
      4'd4:    byte_sel = req_r.arg_b;
      4'd5:    byte_sel = req_r.arg_c;
      4'd6:    byte_sel = req_r.payload_value[31:24];
      4'd7:    byte_sel = req_r.payload_value[23:16];
      4'd8:    byte_sel = req_r.payload_value[15:8];
      4'd9:    byte_sel = req_r.payload_value[7:0];
      4'd10:   byte_sel = crc_r[7:0];
      default: byte_sel = crc_r[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (frame_done) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= q_data;
      idx_r <= '0;
      crc_r <= cfe_pkg::CRC_INIT;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r < cfe_pkg::CRC_SPAN) begin
        crc_r <= cfe_pkg::crc16_byte(crc_r, byte_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_frame_byte_r <= byte_sel;
      out_byte_index_r <= idx_r;
      out_last_byte_r  <= idx_r == cfe_pkg::LAST_IDX;
    end
  end

  `CFE_ASSERT_IMP(a_last_at_end, out_valid_r && out_last_byte_r,
                  out_byte_index_r == cfe_pkg::LAST_IDX, "Last flag off the final index.")
  `CFE_ASSERT_NXT(a_load_restarts, load, busy_r && idx_r == 4'd0 && crc_r == cfe_pkg::CRC_INIT,
                  "Frame load did not restart index and CRC.")
  `CFE_ASSERT_NXT(a_mid_frame_busy, advance && !frame_done, busy_r,
                  "Back end went idle in the middle of a frame.")

endmodule

// ----- design/command_frame_encoder_crc16.sv -----
// Path: an accepted request is registered in the front end, written to the queue, then loaded
// by the back end; its twelve bytes leave the output register one per cycle while the output
// is taken. Requests are paced by this byte rate; the next loads with the last byte.
// The CRC is folded in one byte per cycle as the bytes are sent.
// Reset clears valid and busy flags and queue pointers and count; no clearing pass.
module command_frame_encoder_crc16 #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_command,
  input  logic [7:0]  in_arg_a,
  input  logic [7:0]  in_arg_b,
  input  logic [7:0]  in_arg_c,
  input  logic [31:0] in_payload_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [3:0]  out_byte_index,
  output logic        out_last_byte
);

  logic                push_valid;
  logic                push_ready;
  cfe_pkg::frame_req_t push_data;
  logic                q_valid;
  logic                q_ready;
  cfe_pkg::frame_req_t q_data;

  cfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_arg_a         (in_arg_a),
    .in_arg_b         (in_arg_b),
    .in_arg_c         (in_arg_c),
    .in_payload_value (in_payload_value),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte)
  );

endmodule
